// ===== sv/df1_frame_encoder_defines.svh =====
// ----------------------------------------------------------------------------
// DF1 frame encoder assertion macros
// Shared property wrappers for the encoder modules.
// ----------------------------------------------------------------------------
`ifndef DF1_FRAME_ENCODER_DEFINES_SVH
`define DF1_FRAME_ENCODER_DEFINES_SVH

// Checked outside reset only.
`define DF1FE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define DF1FE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/df1fe_pkg.sv =====
// ----------------------------------------------------------------------------
// DF1 frame encoder package
// Symbols, result step codes, item type and the CRC-16 byte fold.
// ----------------------------------------------------------------------------
package df1fe_pkg;

  localparam logic [7:0]  SYM_DLE  = 8'h10;
  localparam logic [7:0]  SYM_STX  = 8'h02;
  localparam logic [7:0]  SYM_ETX  = 8'h03;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam int unsigned NUM_STEPS = 8;

  // One-hot result steps, in emission order.
  localparam logic [NUM_STEPS-1:0] STEP_HDR_DLE = 8'b0000_0001;
  localparam logic [NUM_STEPS-1:0] STEP_STX     = 8'b0000_0010;
  localparam logic [NUM_STEPS-1:0] STEP_ESC     = 8'b0000_0100;
  localparam logic [NUM_STEPS-1:0] STEP_BODY    = 8'b0000_1000;
  localparam logic [NUM_STEPS-1:0] STEP_TRL_DLE = 8'b0001_0000;
  localparam logic [NUM_STEPS-1:0] STEP_ETX     = 8'b0010_0000;
  localparam logic [NUM_STEPS-1:0] STEP_CRC_LO  = 8'b0100_0000;
  localparam logic [NUM_STEPS-1:0] STEP_CRC_HI  = 8'b1000_0000;

  typedef logic [NUM_STEPS-1:0] step_mask_t;

  typedef struct packed {
    logic [7:0] body_byte;
    logic       first_byte;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    logic  load;
    item_t item;
  } crc_ctl_t;

  // Reflected CRC-16, one byte, LSB first.
  function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] value);
    logic [15:0] c;
    c = crc ^ {8'h00, value};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) c = (c >> 1) ^ CRC_POLY;
      else      c = c >> 1;
    end
    return c;
  endfunction

endpackage

// ===== sv/df1fe_in_stage.sv =====
// ----------------------------------------------------------------------------
// DF1 frame encoder input stage
// One-entry input register; refills in the cycle it is drained.
// ----------------------------------------------------------------------------
module df1fe_in_stage (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  df1fe_pkg::item_t in_item,
  input  logic            take,
  output logic            item_vld,
  output df1fe_pkg::item_t item
);
  import df1fe_pkg::*;

  logic  vld_r, vld_nxt;
  item_t item_r;
  logic  accept;

  assign in_stall = vld_r && !take;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    vld_nxt = vld_r;
    if (accept)    vld_nxt = 1'b1;
    else if (take) vld_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_item;
    end
  end

  assign item_vld = vld_r;
  assign item     = item_r;

endmodule

// ===== sv/df1fe_crc.sv =====
// ----------------------------------------------------------------------------
// DF1 frame encoder CRC
// Running CRC-16; body byte folded at load, ETX folded in the cycle after.
// ----------------------------------------------------------------------------
module df1fe_crc (
  input  logic                clk,
  input  logic                rst_n,
  input  df1fe_pkg::crc_ctl_t ctl,
  output logic [15:0]         crc
);
  import df1fe_pkg::*;

  logic [15:0] crc_r, crc_nxt;
  logic        etx_pend_r, etx_pend_nxt;
  logic [15:0] crc_base;

  assign crc_base = ctl.item.first_byte ? 16'h0000 : crc_r;

  // A closing word holds the sequencer for at least five results, so the
  // ETX fold never meets the next load.
  always_comb begin
    crc_nxt      = crc_r;
    etx_pend_nxt = 1'b0;
    if (ctl.load) begin
      crc_nxt      = crc_fold(crc_base, ctl.item.body_byte);
      etx_pend_nxt = ctl.item.last_byte;
    end else if (etx_pend_r) begin
      crc_nxt = crc_fold(crc_r, SYM_ETX);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r      <= 16'h0000;
      etx_pend_r <= 1'b0;
    end else begin
      crc_r      <= crc_nxt;
      etx_pend_r <= etx_pend_nxt;
    end
  end

  assign crc = crc_r;

endmodule

// ===== sv/df1fe_seq.sv =====
// ----------------------------------------------------------------------------
// DF1 frame encoder sequencer
// Holds the current word's pending result steps and emits one per cycle while out_stall is low.
// ----------------------------------------------------------------------------
`include "df1_frame_encoder_defines.svh"

module df1fe_seq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 item_vld,
  input  df1fe_pkg::item_t     item,
  output logic                 take,
  output df1fe_pkg::crc_ctl_t  crc_ctl,
  input  logic [15:0]          crc,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           out_byte,
  output logic                 out_end_of_run,
  output logic                 out_end_of_frame
);
  import df1fe_pkg::*;

  step_mask_t rem_r, rem_nxt;
  step_mask_t cur;
  step_mask_t rem_left;
  step_mask_t load_mask;
  logic [7:0] byte_r;
  logic       advance;
  logic       finishing;

  assign cur       = rem_r & (~rem_r + step_mask_t'(1));
  assign rem_left  = rem_r & ~cur;
  assign out_valid = |rem_r;
  assign advance   = out_valid && !out_stall;
  assign finishing = advance && (rem_left == '0);
  assign take      = item_vld && (!out_valid || finishing);

  assign load_mask = {{4{item.last_byte}}, 1'b1, item.body_byte == SYM_DLE,
                      {2{item.first_byte}}};

  always_comb begin
    rem_nxt = rem_r;
    if (take)         rem_nxt = load_mask;
    else if (advance) rem_nxt = rem_left;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
    end else begin
      rem_r <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      byte_r <= item.body_byte;
    end
  end

  assign crc_ctl.load = take;
  assign crc_ctl.item = item;

  always_comb begin
    case (cur)
      STEP_HDR_DLE: out_byte = SYM_DLE;
      STEP_STX:     out_byte = SYM_STX;
      STEP_ESC:     out_byte = SYM_DLE;
      STEP_BODY:    out_byte = byte_r;
      STEP_TRL_DLE: out_byte = SYM_DLE;
      STEP_ETX:     out_byte = SYM_ETX;
      STEP_CRC_LO:  out_byte = crc[7:0];
      STEP_CRC_HI:  out_byte = crc[15:8];
      default:      out_byte = 8'h00;
    endcase
  end

  assign out_end_of_run   = out_valid && (rem_left == '0);
  assign out_end_of_frame = out_valid && (cur == STEP_CRC_HI);

  `DF1FE_ASSERT_ALWAYS(a_idle_after_rst, !rst_n |=> !out_valid, "results pending after reset")
  `DF1FE_ASSERT(a_one_step, out_valid |-> $onehot(cur), "current step not one-hot")
  `DF1FE_ASSERT(a_eof_ends_run, out_valid && out_end_of_frame |-> out_end_of_run,
                "frame end not on last result of the word")
  `DF1FE_ASSERT(a_hdr_first, take && item.first_byte |=> out_byte == SYM_DLE && cur == STEP_HDR_DLE,
                "opening word does not start with DLE")

endmodule

// ===== sv/df1_frame_encoder.sv =====
// ----------------------------------------------------------------------------
// DF1 frame encoder
// Frames and escapes a DF1 body byte stream and appends DLE ETX and CRC-16.
// ----------------------------------------------------------------------------
// channel  direction  handshake           payload
// in       input      in_valid/in_stall   in_body_byte, in_first_byte, in_last_byte
// out      output     out_valid/out_stall out_byte, out_end_of_run, out_end_of_frame
//
// A word holds the sequencer until all its results are taken; it makes
// 1 for a plain byte, +1 for an escaped DLE, +2 on first, +4 on last (max 8).
// The input register refills in the cycle the last result is taken, so plain
// bytes stream at one word per cycle while out_stall is low.
// rst_n clears the CRC and drops all pending results; out_stall freezes the
// sequencer and backs up into in_stall once the input register is full.
// ----------------------------------------------------------------------------
module df1_frame_encoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_body_byte,
  input  logic       in_first_byte,
  input  logic       in_last_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_end_of_run,
  output logic       out_end_of_frame
);
  import df1fe_pkg::*;

  item_t       in_item;
  item_t       item;
  logic        item_vld;
  logic        take;
  crc_ctl_t    crc_ctl;
  logic [15:0] crc;

  assign in_item.body_byte  = in_body_byte;
  assign in_item.first_byte = in_first_byte;
  assign in_item.last_byte  = in_last_byte;

  df1fe_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .take     (take),
    .item_vld (item_vld),
    .item     (item)
  );

  df1fe_crc u_crc (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (crc_ctl),
    .crc   (crc)
  );

  df1fe_seq u_seq (
    .clk              (clk),
    .rst_n            (rst_n),
    .item_vld         (item_vld),
    .item             (item),
    .take             (take),
    .crc_ctl          (crc_ctl),
    .crc              (crc),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_byte         (out_byte),
    .out_end_of_run   (out_end_of_run),
    .out_end_of_frame (out_end_of_frame)
  );

endmodule
